// ===== rtl/core/sdrf_pkg.sv =====
// ----------------------------------------------------------------------------
// sdrf_pkg
// shared types, constants and the per-kind threshold table of the
// sensor deadband report filter
// ----------------------------------------------------------------------------
package sdrf_pkg;

  localparam int DEVICES_DEFAULT = 16;
  localparam int SENSORS_DEFAULT = 8;

  localparam logic [31:0] TIMEOUT_RESET    = 32'd120000;
  localparam logic [15:0] FULL_SCALE_RESET = 16'd4095;
  localparam logic [15:0] GLITCH_LIMIT     = 16'hfff0;
  localparam int          PERCENT_SCALE    = 100;

  // moisture divider: quotient never exceeds the percent scale while the sample is within full scale
  localparam int DIVIDEND_W = 24;
  localparam int QUOT_W     = 7;
  localparam int STEP_W     = 3;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_REPORT_TIMEOUT = 1'b0,
    CFG_ADC_FULL_SCALE = 1'b1
  } cfg_index_t;

  typedef enum logic [3:0] {
    KIND_BATTERY     = 4'd0,
    KIND_LIGHT       = 4'd1,
    KIND_MOTION      = 4'd2,
    KIND_MOISTURE    = 4'd3,
    KIND_TEMPERATURE = 4'd4,
    KIND_CONTACT     = 4'd5,
    KIND_FACE        = 4'd6,
    KIND_PARTICLES   = 4'd7,
    KIND_UV          = 4'd8,
    KIND_AGS_AIR     = 4'd9,
    KIND_PMS_AIR     = 4'd10,
    KIND_CCS_AIR     = 4'd11,
    KIND_FORCE       = 4'd12
  } kind_t;

  localparam logic [3:0] KIND_COUNT = 4'd13;

  // deadband threshold chosen when a slot is claimed
  function automatic logic [1:0] kind_threshold(input logic [3:0] kind);
    logic [1:0] thr;
    case (kind)
      KIND_BATTERY:   thr = 2'd1;
      KIND_MOISTURE:  thr = 2'd2;
      KIND_PARTICLES: thr = 2'd2;
      KIND_UV:        thr = 2'd1;
      KIND_AGS_AIR:   thr = 2'd1;
      KIND_PMS_AIR:   thr = 2'd1;
      KIND_CCS_AIR:   thr = 2'd1;
      default:        thr = 2'd0;
    endcase
    return thr;
  endfunction

  typedef struct packed {
    logic        used;
    logic [1:0]  thr;
    logic [15:0] value;
    logic [31:0] time_ms;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

  typedef struct packed {
    logic load;
    logic clear;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic moisture;
    logic div_done;
  } dp_status_t;

endpackage

// ===== rtl/core/sensor_deadband_report_filter_core.sv =====
// ----------------------------------------------------------------------------
// sensor_deadband_report_filter_core
// report-by-exception filter: per-slot deadband and timeout on sensor samples
// ----------------------------------------------------------------------------
//
// channel   direction  handshake          payload
// --------  ---------  -----------------  -----------------------------------
// request   in         start & !busy      device_slot sensor_slot sensor_kind
//                                         sample_value now_ms
// report    out        report_valid       out_device out_sensor out_kind
//                      (one-cycle strobe) report_value by_timeout
// config    in         cfg_we             cfg_index cfg_data
//
// sequencing: an accepted request passes the read and finish states before the
//   next accept; a moisture request also waits in the divider state for the
//   bit-serial percentage divider (one quotient bit per cycle, 7 bits)
// the slot table is one ram with registered read: a read cycle, then (after any
//   divider wait) a commit cycle that writes the slot back and registers the report
// reset: synchronous, active high; afterwards a clearing pass walks the
//   slot table, one entry a cycle, all DEVICES * SENSORS_PER_DEVICE entries
//   (128 by default) with busy high; config writes are taken throughout
// the report side cannot stall: a report is on the ports for one cycle
//
module sensor_deadband_report_filter_core #(
  parameter int DEVICES            = sdrf_pkg::DEVICES_DEFAULT,
  parameter int SENSORS_PER_DEVICE = sdrf_pkg::SENSORS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  // request channel
  input  logic                             start,
  output logic                             busy,
  input  logic [3:0]                       device_slot,
  input  logic [2:0]                       sensor_slot,
  input  logic [3:0]                       sensor_kind,
  input  logic [15:0]                      sample_value,
  input  logic [31:0]                      now_ms,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [sdrf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sdrf_pkg::CFG_DATA_W-1:0]  cfg_data,
  // report channel
  output logic                             report_valid,
  output logic [3:0]                       out_device,
  output logic [2:0]                       out_sensor,
  output logic [3:0]                       out_kind,
  output logic [15:0]                      report_value,
  output logic                             by_timeout
);

  // command and status between sequencer and datapath
  sdrf_pkg::ctrl_cmd_t  cmd;
  sdrf_pkg::dp_status_t status;

  // sequencer: clear sweep, read, divider wait, commit
  sdrf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // datapath: request registers, slot ram, divider, decision, report regs
  sdrf_datapath #(
    .DEVICES            (DEVICES),
    .SENSORS_PER_DEVICE (SENSORS_PER_DEVICE)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .device_slot  (device_slot),
    .sensor_slot  (sensor_slot),
    .sensor_kind  (sensor_kind),
    .sample_value (sample_value),
    .now_ms       (now_ms),
    .report_valid (report_valid),
    .out_device   (out_device),
    .out_sensor   (out_sensor),
    .out_kind     (out_kind),
    .report_value (report_value),
    .by_timeout   (by_timeout)
  );

  // at most one report per request: the commit cycle is always followed by idle
  a_single_report: assert property (@(posedge clk) disable iff (rst)
    report_valid |=> !report_valid)
    else $error("report strobe held for more than one cycle");

  // a report only comes out of a request that was being worked on
  a_report_from_busy: assert property (@(posedge clk) disable iff (rst)
    report_valid |-> $past(busy))
    else $error("report without a request in flight");

  // an accepted request keeps the block busy while it is worked on
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a request");

  // no commit cycle may follow directly on an accept
  a_no_report_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !report_valid)
    else $error("report one cycle after accept");

endmodule

// ===== rtl/core/sdrf_ram.sv =====
// ----------------------------------------------------------------------------
// sdrf_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module sdrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/sdrf_ctrl.sv =====
// ----------------------------------------------------------------------------
// sdrf_ctrl
// sequencer: clearing sweep, slot read, divider wait, commit
// ----------------------------------------------------------------------------
module sdrf_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  sdrf_pkg::dp_status_t  status,
  output sdrf_pkg::ctrl_cmd_t   cmd,
  output logic                  busy
);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_READ   = 5'b00100,
    S_DIV    = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = status.moisture ? S_DIV : S_FINISH;
      end
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.commit = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  assign busy = rst || (state != S_IDLE);

endmodule

// ===== rtl/core/sdrf_datapath.sv =====
// ----------------------------------------------------------------------------
// sdrf_datapath
// request registers, slot table, moisture divider, decision and result
// ----------------------------------------------------------------------------
module sdrf_datapath #(
  parameter int DEVICES            = sdrf_pkg::DEVICES_DEFAULT,
  parameter int SENSORS_PER_DEVICE = sdrf_pkg::SENSORS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  sdrf_pkg::ctrl_cmd_t              cmd,
  output sdrf_pkg::dp_status_t             status,
  input  logic                             cfg_we,
  input  logic [sdrf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sdrf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [3:0]                       device_slot,
  input  logic [2:0]                       sensor_slot,
  input  logic [3:0]                       sensor_kind,
  input  logic [15:0]                      sample_value,
  input  logic [31:0]                      now_ms,
  output logic                             report_valid,
  output logic [3:0]                       out_device,
  output logic [2:0]                       out_sensor,
  output logic [3:0]                       out_kind,
  output logic [15:0]                      report_value,
  output logic                             by_timeout
);

  localparam int SLOTS  = DEVICES * SENSORS_PER_DEVICE;
  localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(SLOTS - 1);
  localparam int DW = sdrf_pkg::DIVIDEND_W;
  localparam logic [sdrf_pkg::STEP_W-1:0] STEPS =
    sdrf_pkg::STEP_W'(sdrf_pkg::QUOT_W);

  // configuration
  logic [31:0] timeout_cfg;
  logic [15:0] full_scale;

  // request registers
  logic [3:0]        dev_q;
  logic [2:0]        sen_q;
  logic [3:0]        kind_q;
  logic [15:0]       raw_q;
  logic [31:0]       now_q;
  logic [ADDR_W-1:0] slot_q;
  logic              ok_q;

  // divider
  logic [DW-1:0]                 rem;
  logic [DW-1:0]                 dsh;
  logic [sdrf_pkg::QUOT_W-1:0]   quot;
  logic [sdrf_pkg::STEP_W-1:0]   step_cnt;

  logic [ADDR_W-1:0] clr_addr;

  logic [31:0]                   slot_full;
  logic                          in_ok;
  logic                          ram_we;
  logic [ADDR_W-1:0]             ram_waddr;
  logic [sdrf_pkg::ENTRY_W-1:0]  ram_wdata;
  logic [sdrf_pkg::ENTRY_W-1:0]  ram_rdata;
  sdrf_pkg::slot_entry_t         ent;
  sdrf_pkg::slot_entry_t         new_ent;
  logic [1:0]                    thr;
  logic [15:0]                   last_v;
  logic [31:0]                   last_t;
  logic [15:0]                   moist_v;
  logic [15:0]                   cond_v;
  logic [15:0]                   diff;
  logic                          deadband;
  logic                          timed_out;
  logic                          emit;
  logic                          upd;
  logic [15:0]                   shown;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_cfg <= sdrf_pkg::TIMEOUT_RESET;
      full_scale  <= sdrf_pkg::FULL_SCALE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sdrf_pkg::CFG_REPORT_TIMEOUT: timeout_cfg <= cfg_data;
        sdrf_pkg::CFG_ADC_FULL_SCALE: full_scale  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign slot_full = 32'(device_slot) * 32'(SENSORS_PER_DEVICE) + 32'(sensor_slot);
  assign in_ok = (32'(device_slot) < 32'(DEVICES))
              && (32'(sensor_slot) < 32'(SENSORS_PER_DEVICE))
              && (sensor_kind < sdrf_pkg::KIND_COUNT);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dev_q  <= device_slot;
      sen_q  <= sensor_slot;
      kind_q <= sensor_kind;
      raw_q  <= sample_value;
      now_q  <= now_ms;
      slot_q <= slot_full[ADDR_W-1:0];
      ok_q   <= in_ok;
    end
  end

  // restoring divide of (raw * 200 + fs) by 2 * fs, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= STEPS;
    end else if (cmd.load) begin
      rem      <= DW'(sample_value) * DW'(2 * sdrf_pkg::PERCENT_SCALE) + DW'(full_scale);
      dsh      <= DW'({full_scale, 1'b0}) << (sdrf_pkg::QUOT_W - 1);
      quot     <= '0;
      step_cnt <= '0;
    end else if (step_cnt != STEPS) begin
      if (rem >= dsh) begin
        rem  <= rem - dsh;
        quot <= {quot[sdrf_pkg::QUOT_W-2:0], 1'b1};
      end else begin
        quot <= {quot[sdrf_pkg::QUOT_W-2:0], 1'b0};
      end
      dsh      <= dsh >> 1;
      step_cnt <= step_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign status.clear_last = (clr_addr == LAST_SLOT);
  assign status.moisture   = (kind_q == sdrf_pkg::KIND_MOISTURE);
  assign status.div_done   = (step_cnt == STEPS);

  // slot entry, with a fresh claim for an unused slot
  assign ent    = sdrf_pkg::slot_entry_t'(ram_rdata);
  assign thr    = ent.used ? ent.thr : sdrf_pkg::kind_threshold(kind_q);
  assign last_v = ent.used ? ent.value : 16'd0;
  assign last_t = ent.used ? ent.time_ms : 32'd0;

  assign moist_v = ((full_scale == 16'd0) || (raw_q > full_scale)) ? 16'd0 : 16'(quot);

  always_comb begin
    case (kind_q)
      sdrf_pkg::KIND_LIGHT, sdrf_pkg::KIND_UV, sdrf_pkg::KIND_FORCE:
        cond_v = (raw_q > sdrf_pkg::GLITCH_LIMIT) ? 16'd0 : raw_q;
      sdrf_pkg::KIND_MOISTURE:
        cond_v = moist_v;
      default:
        cond_v = raw_q;
    endcase
  end

  assign diff      = (last_v > cond_v) ? (last_v - cond_v) : (cond_v - last_v);
  assign deadband  = (diff >= {14'd0, thr});
  assign timed_out = ((now_q - last_t) > timeout_cfg);

  always_comb begin
    case (kind_q)
      sdrf_pkg::KIND_BATTERY:   emit = deadband;
      sdrf_pkg::KIND_CONTACT:   emit = 1'b1;
      sdrf_pkg::KIND_FACE,
      sdrf_pkg::KIND_PARTICLES: emit = 1'b0;
      default:                  emit = deadband || timed_out;
    endcase
  end

  assign upd = emit && (kind_q != sdrf_pkg::KIND_BATTERY);

  assign new_ent.used    = 1'b1;
  assign new_ent.thr     = thr;
  assign new_ent.value   = upd ? cond_v : last_v;
  assign new_ent.time_ms = upd ? now_q : last_t;

  assign ram_we    = cmd.clear || (cmd.commit && ok_q && (!ent.used || upd));
  assign ram_waddr = cmd.clear ? clr_addr : slot_q;
  assign ram_wdata = cmd.clear ? '0 : new_ent;

  sdrf_ram #(
    .WIDTH (sdrf_pkg::ENTRY_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (slot_q),
    .rdata (ram_rdata)
  );

  assign shown = ((kind_q == sdrf_pkg::KIND_MOTION) || (kind_q == sdrf_pkg::KIND_CONTACT))
               ? {15'd0, (cond_v != 16'd0)} : cond_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      report_valid <= 1'b0;
    end else begin
      report_valid <= cmd.commit && ok_q && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_device   <= dev_q;
      out_sensor   <= sen_q;
      out_kind     <= kind_q;
      report_value <= shown;
      by_timeout   <= timed_out;
    end
  end

endmodule
